// ===== design/truncated_series_multiply_mod_defines.svh =====
// Assertion macros shared by the series multiplier
`ifndef TRUNCATED_SERIES_MULTIPLY_MOD_DEFINES_SVH
`define TRUNCATED_SERIES_MULTIPLY_MOD_DEFINES_SVH

// Condition implies consequence in the same cycle
`define TSM_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle
`define TSM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tsm_pkg.sv =====
`timescale 1ns / 1ps
package tsm_pkg;

   localparam int TSM_MAX_TERMS = 64;
   localparam logic [31:0] TSM_MODULUS_RESET = 32'd2147483647;
   localparam int TSM_REM_STEPS = 64;
   localparam int TSM_REM_CW = $clog2(TSM_REM_STEPS + 1);

   // Request action codes
   localparam logic [1:0] ACT_LOAD_A  = 2'd0;
   localparam logic [1:0] ACT_LOAD_B  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   // Result status codes
   typedef enum logic [1:0] {
      KIND_COEF  = 2'd0,
      KIND_ZERO  = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_OVF   = 2'd3
   } kind_type;

   typedef struct packed {
      logic     load;
      logic     scan_a;
      logic     scan_b;
      logic     sel_b;
      logic     scan_step;
      logic     scan_record;
      logic     scan_empty;
      logic     rem_start;
      logic     rem_scan;
      logic     prep;
      logic     term_init;
      logic     mul;
      logic     acc_add;
      logic     j_step;
      logic     emit;
      kind_type kind;
      logic     i_step;
      logic     clear;
   } cmd_type;

   typedef struct packed {
      logic ovf;
      logic empty;
      logic rem_done;
      logic rem_zero;
      logic scan_end;
      logic zero_case;
      logic term_end;
      logic run_end;
      logic out_free;
   } stat_type;

   // Saturate a wide signed sum to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic [35:0] v);
      logic [31:0] r;
      if (v[35] && (v[34:31] != 4'hF)) begin
         r = 32'h8000_0000;
      end else if (!v[35] && (v[34:31] != 4'h0)) begin
         r = 32'h7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== design/truncated_series_multiply_mod.sv =====
`timescale 1ns / 1ps
// Load requests are accepted whenever the block is idle. A compute request runs one item at a time.
// Scanning for leading zeros (one reducer pass per coefficient looked at) and each
// multiply-accumulate both use the shared bit-serial reducer (64 steps); for P output
// terms the product takes P * (P + 1) / 2 multiply-accumulates.
// Each result leaves through an output register; the next term starts while it waits.
// Synchronous reset restores the modulus and clears counts, exponents and overflow.
module truncated_series_multiply_mod #(
   parameter int MAX_TERMS = tsm_pkg::TSM_MAX_TERMS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // coef [31:0], start_exp [63:32]
   input  logic [1:0]  req_tuser,   // action [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // coef_out [31:0], exponent [63:32]
   output logic [1:0]  rsp_tuser,   // status [1:0]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import tsm_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic        idle;
   logic [31:0] rsp_coef, rsp_exp;

   assign req_tready = idle;

   tsm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_tvalid && idle),
      .action   (req_tuser),
      .stat     (stat),
      .cmd      (cmd),
      .idle     (idle)
   );

   tsm_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .action      (req_tuser),
      .coef        (req_tdata[31:0]),
      .start_exp   (req_tdata[63:32]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_coef    (rsp_coef),
      .rsp_exp     (rsp_exp),
      .rsp_status  (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {rsp_exp, rsp_coef};

endmodule

// ===== design/tsm_rem.sv =====
`timescale 1ns / 1ps
module tsm_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] modulus,
   output logic        busy,
   output logic        done,
   output logic [31:0] rem
);
   import tsm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [TSM_REM_CW-1:0] cnt_ff, cnt_in;
   logic [63:0]           x_ff, x_in;
   logic [31:0]           r_ff, r_in;
   logic [32:0]           trial;

   // Shift one dividend bit in per cycle, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      trial   = {r_ff, x_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = TSM_REM_CW'(TSM_REM_STEPS);
         x_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         x_in = {x_ff[62:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            r_in = 32'(trial - {1'b0, modulus});
         end else begin
            r_in = trial[31:0];
         end
         cnt_in = cnt_ff - TSM_REM_CW'(1);
         if (cnt_ff == TSM_REM_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = r_ff;

endmodule

// ===== design/tsm_dp.sv =====
`timescale 1ns / 1ps
`include "truncated_series_multiply_mod_defines.svh"
module tsm_dp #(
   parameter int MAX_TERMS = tsm_pkg::TSM_MAX_TERMS
) (
   input  logic              clock,
   input  logic              reset,
   input  tsm_pkg::cmd_type  cmd,
   output tsm_pkg::stat_type stat,
   input  logic [1:0]        action,
   input  logic [31:0]       coef,
   input  logic [31:0]       start_exp,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_coef,
   output logic [31:0]       rsp_exp,
   output logic [1:0]        rsp_status,
   output logic              rsp_last
);
   import tsm_pkg::*;

   localparam int AW = $clog2(MAX_TERMS);
   localparam int CW = $clog2(MAX_TERMS + 1);

   logic [31:0]   mem_a [MAX_TERMS];
   logic [31:0]   mem_b [MAX_TERMS];
   logic [31:0]   rd_a_ff, rd_b_ff;
   logic [31:0]   modulus_ff;
   logic [CW-1:0] count_a_ff, count_b_ff, nz_a_ff, nz_b_ff, i_ff;
   logic [31:0]   base_a_ff, base_b_ff;
   logic          ovf_ff;
   logic [AW-1:0] j_ff, k_ff;
   logic [63:0]   prod_ff;
   logic [31:0]   acc_ff;
   logic [35:0]   bound_ff, nc_ff;
   logic          out_valid_ff;
   logic [31:0]   out_coef_ff, out_exp_ff;
   logic [1:0]    out_status_ff;
   logic          out_last_ff;

   logic          rem_busy, rem_done;
   logic [31:0]   rem_val;
   logic [63:0]   rem_arg;
   logic [32:0]   sum;
   logic [31:0]   acc_in;
   logic [CW-1:0] pc, rest_a, rest_b;
   logic [35:0]   ext_a, ext_b, last_a, last_b, bound_in, nc_in;
   logic          zero_a, zero_b;

   // Operand stores
   always_ff @(posedge clock) begin
      if (cmd.load && action == ACT_LOAD_A && count_a_ff != CW'(MAX_TERMS)) begin
         mem_a[count_a_ff[AW-1:0]] <= coef;
      end
      if (cmd.load && action == ACT_LOAD_B && count_b_ff != CW'(MAX_TERMS)) begin
         mem_b[count_b_ff[AW-1:0]] <= coef;
      end
      rd_a_ff <= mem_a[j_ff];
      rd_b_ff <= mem_b[k_ff];
   end

   // Shared modular reducer
   assign rem_arg = cmd.rem_scan ? {32'd0, (cmd.sel_b ? rd_b_ff : rd_a_ff)} : prod_ff;

   tsm_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.rem_start),
      .dividend (rem_arg),
      .modulus  (modulus_ff),
      .busy     (rem_busy),
      .done     (rem_done),
      .rem      (rem_val)
   );

   // Modular accumulate: both terms below modulus, one subtract
   assign sum    = {1'b0, acc_ff} + {1'b0, rem_val};
   assign acc_in = (sum >= {1'b0, modulus_ff}) ? 32'(sum - {1'b0, modulus_ff}) : sum[31:0];

   // Exponent arithmetic, wide before saturation
   assign ext_a    = {{4{base_a_ff[31]}}, base_a_ff};
   assign ext_b    = {{4{base_b_ff[31]}}, base_b_ff};
   assign last_a   = ext_a + 36'(count_a_ff) - 36'd1;
   assign last_b   = ext_b + 36'(count_b_ff) - 36'd1;
   assign zero_a   = (nz_a_ff == count_a_ff);
   assign zero_b   = (nz_b_ff == count_b_ff);
   assign nc_in    = ext_a + ext_b + 36'(nz_a_ff) + 36'(nz_b_ff);
   always_comb begin
      if (zero_a && zero_b) begin
         bound_in = last_a + last_b + 36'd1;
      end else if (zero_a) begin
         bound_in = last_a + ext_b + 36'(nz_b_ff);
      end else begin
         bound_in = last_b + ext_a + 36'(nz_a_ff);
      end
   end
   assign rest_a = count_a_ff - nz_a_ff;
   assign rest_b = count_b_ff - nz_b_ff;
   assign pc     = (rest_b < rest_a) ? rest_b : rest_a;

   // Operand state, indexes and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= TSM_MODULUS_RESET;
         count_a_ff <= '0;
         count_b_ff <= '0;
         base_a_ff  <= '0;
         base_b_ff  <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            modulus_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            count_a_ff <= '0;
            count_b_ff <= '0;
            base_a_ff  <= '0;
            base_b_ff  <= '0;
            ovf_ff     <= 1'b0;
         end else if (cmd.load && action == ACT_LOAD_A) begin
            if (count_a_ff == CW'(MAX_TERMS)) begin
               ovf_ff <= 1'b1;
            end else begin
               if (count_a_ff == '0) begin
                  base_a_ff <= start_exp;
               end
               count_a_ff <= count_a_ff + CW'(1);
            end
         end else if (cmd.load && action == ACT_LOAD_B) begin
            if (count_b_ff == CW'(MAX_TERMS)) begin
               ovf_ff <= 1'b1;
            end else begin
               if (count_b_ff == '0) begin
                  base_b_ff <= start_exp;
               end
               count_b_ff <= count_b_ff + CW'(1);
            end
         end
      end
      // Scan and product indexes
      if (cmd.scan_a) begin
         j_ff <= '0;
      end else if (cmd.scan_b) begin
         k_ff <= '0;
      end else if (cmd.scan_step) begin
         if (cmd.sel_b) begin
            k_ff <= k_ff + AW'(1);
         end else begin
            j_ff <= j_ff + AW'(1);
         end
      end else if (cmd.term_init) begin
         j_ff <= nz_a_ff[AW-1:0];
         k_ff <= AW'(nz_b_ff + i_ff);
      end else if (cmd.j_step) begin
         j_ff <= j_ff + AW'(1);
         k_ff <= k_ff - AW'(1);
      end
      if (cmd.scan_record) begin
         if (cmd.sel_b) begin
            nz_b_ff <= CW'(k_ff);
         end else begin
            nz_a_ff <= CW'(j_ff);
         end
      end else if (cmd.scan_empty) begin
         if (cmd.sel_b) begin
            nz_b_ff <= count_b_ff;
         end else begin
            nz_a_ff <= count_a_ff;
         end
      end
      if (cmd.prep) begin
         bound_ff <= bound_in;
         nc_ff    <= nc_in;
         i_ff     <= '0;
      end else if (cmd.i_step) begin
         i_ff <= i_ff + CW'(1);
      end
      if (cmd.mul) begin
         prod_ff <= 64'(rd_a_ff) * 64'(rd_b_ff);
      end
      if (cmd.term_init) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_status_ff <= cmd.kind;
         case (cmd.kind)
            KIND_COEF: begin
               out_coef_ff <= acc_ff;
               out_exp_ff  <= sat32(nc_ff + 36'(i_ff));
               out_last_ff <= (i_ff + CW'(1) == pc);
            end
            KIND_ZERO: begin
               out_coef_ff <= '0;
               out_exp_ff  <= sat32(bound_ff);
               out_last_ff <= 1'b1;
            end
            default: begin
               out_coef_ff <= '0;
               out_exp_ff  <= '0;
               out_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_coef   = out_coef_ff;
   assign rsp_exp    = out_exp_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

   assign stat.ovf       = ovf_ff;
   assign stat.empty     = (count_a_ff == '0) || (count_b_ff == '0);
   assign stat.rem_done  = rem_done;
   assign stat.rem_zero  = (rem_val == '0);
   assign stat.scan_end  = cmd.sel_b ? (CW'(k_ff) + CW'(1) == count_b_ff)
                                     : (CW'(j_ff) + CW'(1) == count_a_ff);
   assign stat.zero_case = zero_a || zero_b;
   assign stat.term_end  = (CW'(k_ff) == nz_b_ff);
   assign stat.run_end   = (i_ff + CW'(1) == pc);
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   `TSM_ASSERT_NOW(a_rem_free, clock, reset, cmd.rem_start, !rem_busy, "reducer restarted while busy")
   `TSM_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, !out_valid_ff || rsp_ready, "result overwritten")
   `TSM_ASSERT_NEXT(a_acc_range, clock, reset, cmd.acc_add && modulus_ff != '0, acc_ff < modulus_ff, "accumulator not reduced")

endmodule

// ===== design/tsm_ctrl.sv =====
`timescale 1ns / 1ps
module tsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [1:0]        action,
   input  tsm_pkg::stat_type stat,
   output tsm_pkg::cmd_type  cmd,
   output logic              idle
);
   import tsm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_GO, S_SCAN_WAIT, S_PREP, S_TERM,
      S_MAC_RD, S_MAC_MUL, S_MAC_GO, S_MAC_WAIT, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      sel_b_ff, sel_b_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      sel_b_in = sel_b_ff;
      cmd      = '0;
      cmd.sel_b = sel_b_ff;
      cmd.kind  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               if (action == ACT_COMPUTE) begin
                  if (stat.ovf) begin
                     kind_in  = KIND_OVF;
                     state_in = S_EMIT;
                  end else if (stat.empty) begin
                     kind_in  = KIND_EMPTY;
                     state_in = S_EMIT;
                  end else begin
                     cmd.scan_a = 1'b1;
                     sel_b_in   = 1'b0;
                     state_in   = S_SCAN_RD;
                  end
               end
            end
         end
         // Find the first coefficient that is nonzero mod the modulus
         S_SCAN_RD: state_in = S_SCAN_GO;
         S_SCAN_GO: begin
            cmd.rem_start = 1'b1;
            cmd.rem_scan  = 1'b1;
            state_in      = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            if (stat.rem_done) begin
               if (!stat.rem_zero || stat.scan_end) begin
                  cmd.scan_record = !stat.rem_zero;
                  cmd.scan_empty  = stat.rem_zero;
                  if (!sel_b_ff) begin
                     cmd.scan_b = 1'b1;
                     sel_b_in   = 1'b1;
                     state_in   = S_SCAN_RD;
                  end else begin
                     state_in = S_PREP;
                  end
               end else begin
                  cmd.scan_step = 1'b1;
                  state_in      = S_SCAN_RD;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            if (stat.zero_case) begin
               kind_in  = KIND_ZERO;
               state_in = S_EMIT;
            end else begin
               kind_in  = KIND_COEF;
               state_in = S_TERM;
            end
         end
         // One convolution sum per term, one multiply-reduce per coefficient pair
         S_TERM: begin
            cmd.term_init = 1'b1;
            state_in      = S_MAC_RD;
         end
         S_MAC_RD:  state_in = S_MAC_MUL;
         S_MAC_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_MAC_GO;
         end
         S_MAC_GO: begin
            cmd.rem_start = 1'b1;
            state_in      = S_MAC_WAIT;
         end
         S_MAC_WAIT: begin
            if (stat.rem_done) begin
               cmd.acc_add = 1'b1;
               if (stat.term_end) begin
                  state_in = S_EMIT;
               end else begin
                  cmd.j_step = 1'b1;
                  state_in   = S_MAC_RD;
               end
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (kind_ff != KIND_COEF || stat.run_end) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cmd.i_step = 1'b1;
                  state_in   = S_TERM;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_COEF;
         sel_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         sel_b_ff <= sel_b_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

endmodule
